[src/cts_pkg.sv]
// ----------------------------------------------------------------------------
// Capacitive touch scan package
// Shared widths, record types, register indexes and gesture codes.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Geometry of the scanner.
  localparam int NUM_BUTTONS = 4;
  localparam int ROUND_LOG2  = 3;
  localparam int ROUNDS      = 1 << ROUND_LOG2;
  localparam int TICK_BITS   = 24;
  localparam int SUM_BITS    = TICK_BITS + ROUND_LOG2;
  localparam int RCNT_W      = (ROUND_LOG2 > 0) ? ROUND_LOG2 : 1;
  localparam int BTN_W       = $clog2(NUM_BUTTONS + 1);

  // Configuration register widths.
  localparam int THR_W      = 24;
  localparam int SLIDE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Queue depths between and after the two halves.
  localparam int SQ_DEPTH  = 2;
  localparam int SQ_PTR_W  = $clog2(SQ_DEPTH);
  localparam int SQ_CNT_W  = $clog2(SQ_DEPTH + 1);
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_DLT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_ONLY = 2'd2;

  // Register reset values.
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 24'd64;
  localparam logic [SLIDE_W-1:0] SLIDE_DLT_RST = 2'd2;

  // Gesture kinds.
  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_RIGHT = 2'd1;
  localparam logic [1:0] KIND_LEFT  = 2'd2;

  typedef logic [TICK_BITS-1:0] tick_t;

  // One finished scan: per-button averages and the calibrate flag.
  typedef struct packed {
    tick_t [NUM_BUTTONS-1:0] avg;
    logic                    cal;
  } scan_t;

  // Live configuration.
  typedef struct packed {
    logic [THR_W-1:0]   threshold;
    logic [SLIDE_W-1:0] slide_gap;
    logic               drop_points;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [BTN_W-1:0] touched;
    logic             gvalid;
    logic [1:0]       kind;
    logic [BTN_W-1:0] down;
    logic [BTN_W-1:0] up;
  } result_t;

endpackage

[src/cap_touch_scan_gesture_top.sv]
// ----------------------------------------------------------------------------
// Capacitive touch scanner with gesture tracking
// Averages rounds of RC discharge times, finds the touched button against a
// calibrated baseline and reports point and slide gestures.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Transfer when
// input     in         push / full         push && !full
// result    out        empty / pop         pop && !empty
// config    in         cfg_valid/cfg_ready cfg_valid_i && cfg_ready_o
//
// One round is taken per cycle unless the input stalls; a result follows every ROUNDS rounds.
// A completing round enters a two-entry scan queue; from there a scan passes the
// registered delta stage and then the search and tracker stage into the result queue.
// Reset clears sums, baseline, round count and tracker at once.
// The input stalls only on a scan-completing round while the scan queue is
// full; the back end stalls while its four-entry result queue has no room.
// ----------------------------------------------------------------------------
module cap_touch_scan_gesture_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [23:0]                   tick_b0_i,
  input  logic [23:0]                   tick_b1_i,
  input  logic [23:0]                   tick_b2_i,
  input  logic [23:0]                   tick_b3_i,
  input  logic                          calibrate_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [2:0]                    touched_button_o,
  output logic                          gesture_valid_o,
  output logic [1:0]                    gesture_kind_o,
  output logic [2:0]                    down_button_o,
  output logic [2:0]                    up_button_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import cts_pkg::*;

  tick_t [NUM_BUTTONS-1:0] ticks;
  cfg_t                    cfg;
  logic                    sq_valid;
  scan_t                   sq_data;
  logic                    sq_pop;
  result_t                 result;

  assign ticks[0] = tick_b0_i[TICK_BITS-1:0];
  assign ticks[1] = tick_b1_i[TICK_BITS-1:0];
  assign ticks[2] = tick_b2_i[TICK_BITS-1:0];
  assign ticks[3] = tick_b3_i[TICK_BITS-1:0];

  cts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  cts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .ticks_i     (ticks),
    .calibrate_i (calibrate_i),
    .sq_valid_o  (sq_valid),
    .sq_data_o   (sq_data),
    .sq_pop_i    (sq_pop)
  );

  cts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .sq_valid_i (sq_valid),
    .sq_data_i  (sq_data),
    .sq_pop_o   (sq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result)
  );

  assign touched_button_o = 3'(result.touched);
  assign gesture_valid_o  = result.gvalid;
  assign gesture_kind_o   = result.kind;
  assign down_button_o    = 3'(result.down);
  assign up_button_o      = 3'(result.up);

endmodule

[src/cts_cfg.sv]
// ----------------------------------------------------------------------------
// Capacitive touch configuration registers
// Holds the threshold and gesture options written over the config port.
// ----------------------------------------------------------------------------
module cts_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                          cfg_ready_o,
  output cts_pkg::cfg_t                 cfg_o
);
  import cts_pkg::*;

  cfg_t cfg_d, cfg_q;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:  cfg_d.threshold   = cfg_data_i[THR_W-1:0];
        CFG_SLIDE_DLT:  cfg_d.slide_gap   = cfg_data_i[SLIDE_W-1:0];
        CFG_SLIDE_ONLY: cfg_d.drop_points = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold   <= THRESHOLD_RST;
      cfg_q.slide_gap   <= SLIDE_DLT_RST;
      cfg_q.drop_points <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/cts_front.sv]
// ----------------------------------------------------------------------------
// Capacitive touch scan front end
// Accumulates rounds of discharge ticks and queues each finished scan.
// ----------------------------------------------------------------------------
module cts_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  cts_pkg::tick_t [cts_pkg::NUM_BUTTONS-1:0] ticks_i,
  input  logic                                 calibrate_i,
  output logic                                 sq_valid_o,
  output cts_pkg::scan_t                       sq_data_o,
  input  logic                                 sq_pop_i
);
  import cts_pkg::*;

  logic [SUM_BITS-1:0] sums_q [NUM_BUTTONS];
  logic [SUM_BITS-1:0] sum_next [NUM_BUTTONS];
  logic [RCNT_W-1:0]   rcnt_d, rcnt_q;
  logic                last_round;
  logic                accept;
  logic                sq_push;
  scan_t               scan_d;

  scan_t               sq_mem [SQ_DEPTH];
  logic [SQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [SQ_CNT_W-1:0] sq_count_d, sq_count_q;

  // Input side stalls only on the round that would need a queue slot.
  assign last_round = (rcnt_q == RCNT_W'(ROUNDS - 1));
  assign full_o     = last_round && (sq_count_q == SQ_CNT_W'(SQ_DEPTH));
  assign accept     = push_i && !full_o;
  assign sq_push    = accept && last_round;

  // Running sums and the averages of a completing scan.
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      sum_next[b]   = sums_q[b] + SUM_BITS'(ticks_i[b]);
      scan_d.avg[b] = sum_next[b][ROUND_LOG2 +: TICK_BITS];
    end
    scan_d.cal = calibrate_i;
  end

  assign rcnt_d = last_round ? '0 : rcnt_q + RCNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q <= '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        sums_q[b] <= '0;
      end
    end else if (accept) begin
      rcnt_q <= rcnt_d;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        sums_q[b] <= last_round ? '0 : sum_next[b];
      end
    end
  end

  // Scan queue toward the back end.
  assign sq_count_d = sq_count_q + SQ_CNT_W'(sq_push) - SQ_CNT_W'(sq_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      sq_count_q <= '0;
    end else begin
      sq_count_q <= sq_count_d;
      if (sq_push) begin
        wr_ptr_q <= wr_ptr_q + SQ_PTR_W'(1);
      end
      if (sq_pop_i) begin
        rd_ptr_q <= rd_ptr_q + SQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_push) begin
      sq_mem[wr_ptr_q] <= scan_d;
    end
  end

  assign sq_valid_o = (sq_count_q != '0);
  assign sq_data_o  = sq_mem[rd_ptr_q];

endmodule

[src/cts_back.sv]
// ----------------------------------------------------------------------------
// Capacitive touch scan back end
// Baseline compare, touched-button search, gesture tracking and result queue.
// ----------------------------------------------------------------------------
module cts_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cts_pkg::cfg_t        cfg_i,
  input  logic                 sq_valid_i,
  input  cts_pkg::scan_t       sq_data_i,
  output logic                 sq_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output cts_pkg::result_t     result_o
);
  import cts_pkg::*;

  // Delta stage.
  tick_t                  baseline_q [NUM_BUTTONS];
  tick_t                  delta_d [NUM_BUTTONS];
  tick_t                  delta_q [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] hit_d, hit_q;
  logic                   a_valid_q;
  logic                   take;

  // Search and tracker stage.
  tick_t                  best;
  logic [BTN_W-1:0]       found;
  logic                   trk_d, trk_q;
  logic [BTN_W-1:0]       first_d, first_q;
  logic [BTN_W-1:0]       last_d, last_q;
  logic [BTN_W-1:0]       sdelta;
  result_t                res;

  // Result queue.
  result_t                oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]    oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0]    oq_count_q;
  logic                   oq_pop;

  // Take a scan only when the result queue has room for everything in flight.
  assign take = sq_valid_i &&
                ((OQ_CNT_W + 1)'(oq_count_q) + (OQ_CNT_W + 1)'(a_valid_q)
                 < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign sq_pop_o = take;

  // Per-button delta above baseline and threshold hit.
  always_comb begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      delta_d[b] = (sq_data_i.avg[b] > baseline_q[b]) ?
                   sq_data_i.avg[b] - baseline_q[b] : '0;
      hit_d[b]   = !sq_data_i.cal && (delta_d[b] > cfg_i.threshold);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        baseline_q[b] <= '0;
      end
    end else begin
      a_valid_q <= take;
      if (take && sq_data_i.cal) begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          baseline_q[b] <= sq_data_i.avg[b];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      delta_q <= delta_d;
      hit_q   <= hit_d;
    end
  end

  // Largest qualifying delta; the lowest button wins a tie.
  always_comb begin
    best  = '0;
    found = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (hit_q[b] && (delta_q[b] > best)) begin
        best  = delta_q[b];
        found = BTN_W'(b + 1);
      end
    end
  end

  // Gesture tracker: press, hold and release with slide classification.
  assign sdelta = BTN_W'(cfg_i.slide_gap);

  always_comb begin
    trk_d       = trk_q;
    first_d     = first_q;
    last_d      = last_q;
    res         = '0;
    res.touched = found;
    if (!trk_q) begin
      if (found != '0) begin
        trk_d   = 1'b1;
        first_d = found;
        last_d  = found;
      end
    end else if (found != '0) begin
      last_d = found;
    end else begin
      trk_d = 1'b0;
      priority if ((last_q > first_q) && ((last_q - first_q) >= sdelta)) begin
        res.gvalid = 1'b1;
        res.kind   = KIND_RIGHT;
        res.down   = first_q;
        res.up     = last_q;
      end else if ((first_q > last_q) && ((first_q - last_q) >= sdelta)) begin
        res.gvalid = 1'b1;
        res.kind   = KIND_LEFT;
        res.down   = first_q;
        res.up     = last_q;
      end else if (!cfg_i.drop_points) begin
        res.gvalid = 1'b1;
        res.kind   = KIND_POINT;
        res.down   = first_q;
        res.up     = first_q;
      end else begin
        res.gvalid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q   <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end else if (a_valid_q) begin
      trk_q   <= trk_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // Result queue; every finished scan gives exactly one entry.
  assign empty_o = (oq_count_q == '0);
  assign oq_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q    <= '0;
      oq_rd_q    <= '0;
      oq_count_q <= '0;
    end else begin
      oq_count_q <= oq_count_q + OQ_CNT_W'(a_valid_q) - OQ_CNT_W'(oq_pop);
      if (a_valid_q) begin
        oq_wr_q <= oq_wr_q + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + OQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      oq_mem[oq_wr_q] <= res;
    end
  end

  assign result_o = oq_mem[oq_rd_q];

endmodule

[src/cts_checker.sv]
// ----------------------------------------------------------------------------
// Capacitive touch scan port checker
// Watches the result port for well-formed gesture reports.
// ----------------------------------------------------------------------------
module cts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] touched_button_o,
  input logic       gesture_valid_o,
  input logic [1:0] gesture_kind_o,
  input logic [2:0] down_button_o,
  input logic [2:0] up_button_o
);
  import cts_pkg::*;

  // A waiting result stays until it is transferred.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(touched_button_o)))
    else $error("waiting result changed before transfer");

  // Touched button stays within the button range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (touched_button_o <= 3'(NUM_BUTTONS)))
    else $error("touched button out of range");

  // Without a report, the gesture fields are cleared.
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !gesture_valid_o) |->
      (gesture_kind_o == KIND_POINT && down_button_o == 3'd0 && up_button_o == 3'd0))
    else $error("gesture fields set without a report");

  // A reported gesture ends a scan with no touch and names real buttons.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && gesture_valid_o) |->
      (touched_button_o == 3'd0 && down_button_o != 3'd0 && up_button_o != 3'd0))
    else $error("gesture reported on a touched scan or without buttons");

  // A point ends where it started.
  a_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && gesture_valid_o && gesture_kind_o == KIND_POINT) |->
      (up_button_o == down_button_o))
    else $error("point gesture with differing buttons");

endmodule

bind cap_touch_scan_gesture_top cts_checker u_cts_checker (.*);

[tb/cap_touch_scan_gesture_tb.sv]
// ----------------------------------------------------------------------------
// Capacitive touch scanner testbench
// Drives rounds of discharge ticks through the queue-style input and checks
// every scan result against a cycle-free model of the averaging, baseline,
// touch search and gesture tracker. A short directed table comes first,
// then scripted press, hold and release sequences over several register
// settings, with random idling on both sides and one long result stall.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cts_pkg::*;

  localparam tick_t       TMAX         = '1;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam result_t     NO_RES       = '0;

  // One round of ticks as offered on the input side.
  typedef struct {
    tick_t tick [NUM_BUTTONS];
    logic  cal;
  } round_t;

  // A row of the directed table; want is used only where typed is set.
  typedef struct {
    tick_t   t0, t1, t2, t3;
    logic    cal;
    logic    typed;
    result_t want;
  } drow_t;

  // Register setting and traffic shape of one random phase.
  typedef struct {
    int unsigned thr;
    int unsigned slide;
    bit          only;
    int unsigned send_pct;
    int unsigned recv_pct;
    int unsigned scans;
    bit          squeeze;
  } phase_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  full;
  logic [23:0]           tick_b0_i = '0;
  logic [23:0]           tick_b1_i = '0;
  logic [23:0]           tick_b2_i = '0;
  logic [23:0]           tick_b3_i = '0;
  logic                  calibrate_i = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [2:0]            touched_button_o;
  logic                  gesture_valid_o;
  logic [1:0]            gesture_kind_o;
  logic [2:0]            down_button_o;
  logic [2:0]            up_button_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  cap_touch_scan_gesture_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .tick_b0_i        (tick_b0_i),
    .tick_b1_i        (tick_b1_i),
    .tick_b2_i        (tick_b2_i),
    .tick_b3_i        (tick_b3_i),
    .calibrate_i      (calibrate_i),
    .empty            (empty),
    .pop              (pop),
    .touched_button_o (touched_button_o),
    .gesture_valid_o  (gesture_valid_o),
    .gesture_kind_o   (gesture_kind_o),
    .down_button_o    (down_button_o),
    .up_button_o      (up_button_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Scanner state mirrored by the testbench.
  logic [SUM_BITS-1:0] sum_acc [NUM_BUTTONS];
  tick_t               base_avg [NUM_BUTTONS];
  int unsigned         rounds_in_scan;
  bit                  gesture_live;
  logic [BTN_W-1:0]    press_btn;
  logic [BTN_W-1:0]    lift_btn;
  logic [THR_W-1:0]    thr_reg;
  logic [SLIDE_W-1:0]  slide_reg;
  logic                drop_points_reg;

  // Scan results still owed by the block, oldest first.
  result_t scan_results_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  int unsigned touch_run;
  int unsigned mismatches;
  int unsigned rounds_sent;
  int unsigned scans_checked;
  int unsigned input_stalls;
  int unsigned points_seen, rights_seen, lefts_seen;

  // Directed rows: tied full-scale scan, calibrate release, threshold edge.
  drow_t directed_rows [24] = '{
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b0, NO_RES},
    '{TMAX, TMAX, TMAX, TMAX, 1'b0, 1'b1, '{3'd1, 1'b0, KIND_POINT, 3'd0, 3'd0}},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b0, 1'b0, NO_RES},
    '{24'd0, 24'd0, 24'd0, 24'd0, 1'b1, 1'b1, '{3'd0, 1'b1, KIND_POINT, 3'd1, 3'd1}},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b1, 1'b0, NO_RES},
    '{24'd64, 24'd65, TMAX, 24'd0, 1'b0, 1'b1, '{3'd3, 1'b0, KIND_POINT, 3'd0, 3'd0}}
  };

  phase_t phases [7] = '{
    '{64,       2, 1'b0, 29, 85, 30, 1'b0},
    '{0,        0, 1'b0, 29, 85, 25, 1'b0},
    '{24'hFFFFFF, 3, 1'b1, 85, 29, 10, 1'b0},
    '{300,      1, 1'b1, 85, 29, 30, 1'b0},
    '{3000,     3, 1'b0,  0,  0, 30, 1'b1},
    '{1000,     2, 1'b1,  0,  0, 30, 1'b0},
    '{64,       1, 1'b0,  0,  0, 26, 1'b0}
  };

  // Adds one round to the sums; at the end of a scan it averages, updates
  // the baseline or searches for a touch, and steps the gesture tracker.
  function automatic bit accumulate_round(input round_t r, output result_t res);
    tick_t            avg;
    tick_t            delta;
    tick_t            best;
    logic [BTN_W-1:0] hit;
    int               down_i;
    int               up_i;
    res = '0;
    best = '0;
    hit = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) sum_acc[b] += SUM_BITS'(r.tick[b]);
    rounds_in_scan++;
    if (rounds_in_scan < ROUNDS) return 1'b0;
    rounds_in_scan = 0;

    for (int b = 0; b < NUM_BUTTONS; b++) begin
      avg = tick_t'(sum_acc[b] / ROUNDS);
      sum_acc[b] = '0;
      if (r.cal) begin
        base_avg[b] = avg;
      end else begin
        delta = (avg > base_avg[b]) ? avg - base_avg[b] : '0;
        // Strictly above threshold, and only a larger delta takes over.
        if (delta > thr_reg && delta > best) begin
          best = delta;
          hit = BTN_W'(b + 1);
        end
      end
    end
    res.touched = hit;

    // Press, hold and release of the gesture tracker.
    if (!gesture_live) begin
      if (hit != '0) begin
        gesture_live = 1'b1;
        press_btn = hit;
        lift_btn = hit;
      end
    end else if (hit != '0) begin
      lift_btn = hit;
    end else begin
      gesture_live = 1'b0;
      down_i = int'(press_btn);
      up_i = int'(lift_btn);
      if (up_i > down_i && up_i - down_i >= int'(slide_reg)) begin
        res.gvalid = 1'b1;
        res.kind = KIND_RIGHT;
        res.down = press_btn;
        res.up = lift_btn;
      end else if (down_i > up_i && down_i - up_i >= int'(slide_reg)) begin
        res.gvalid = 1'b1;
        res.kind = KIND_LEFT;
        res.down = press_btn;
        res.up = lift_btn;
      end else if (!drop_points_reg) begin
        res.gvalid = 1'b1;
        res.kind = KIND_POINT;
        res.down = press_btn;
        res.up = press_btn;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d, want %0d", $time, what, got, want);
  endtask

  // Offers one round and waits for its transfer, then predicts.
  task automatic send_round(input round_t r, output bit scan_done, output result_t res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    tick_b0_i <= r.tick[0];
    tick_b1_i <= r.tick[1];
    tick_b2_i <= r.tick[2];
    tick_b3_i <= r.tick[3];
    calibrate_i <= r.cal;
    do begin
      @(posedge clk_i);
      if (full) input_stalls++;
    end while (full);
    rounds_sent++;
    scan_done = accumulate_round(r, res);
  endtask

  // One full scan: a calibrate scan, a noise scan, or a scripted scan that
  // either touches one button or lets go, so gestures form and end.
  task automatic send_scan();
    tick_t           lvl [NUM_BUTTONS];
    tick_t           jit [NUM_BUTTONS];
    round_t          r;
    result_t         res;
    bit              done;
    bit              noise;
    bit              cal;
    int unsigned     pick;
    int unsigned     target;
    int unsigned     other;
    longint unsigned v;
    longint unsigned jmax;
    pick = $urandom_range(0, 99);
    noise = (pick < 10);
    cal = (pick >= 10 && pick < 18);
    target = 0;
    for (int b = 0; b < NUM_BUTTONS; b++) lvl[b] = '0;

    if (cal) begin
      for (int b = 0; b < NUM_BUTTONS; b++)
        lvl[b] = ($urandom_range(0, 3) == 0) ? tick_t'($urandom)
                                              : tick_t'($urandom_range(0, 20'hFFFFF));
    end else if (!noise) begin
      if (touch_run == 0) begin
        touch_run = $urandom_range(1, 4);
      end else begin
        target = $urandom_range(1, NUM_BUTTONS);
        touch_run--;
      end
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (b + 1 == target)
          v = 64'(base_avg[b]) + 64'(thr_reg) + 64'd1 + 64'($urandom_range(0, 5000));
        else if ($urandom_range(0, 3) == 0)
          v = (base_avg[b] > tick_t'(200)) ?
              64'(base_avg[b]) - 64'($urandom_range(0, 200)) : 64'd0;
        else
          v = 64'(base_avg[b]) +
              64'($urandom_range(0, (thr_reg > THR_W'(4000)) ? 4000 : int'(thr_reg)));
        lvl[b] = (v > 64'(TMAX)) ? TMAX : tick_t'(v);
      end
      // Now and then a second button matches the touched one.
      if (target != 0 && $urandom_range(0, 4) == 0) begin
        other = $urandom_range(0, NUM_BUTTONS - 1);
        lvl[other] = lvl[target - 1];
      end
    end

    for (int k = 0; k < ROUNDS; k++) begin
      if (noise) begin
        for (int b = 0; b < NUM_BUTTONS; b++) r.tick[b] = tick_t'($urandom);
        r.cal = 1'($urandom_range(0, 1));
      end else begin
        // Paired jitter leaves the scan average exactly on the level.
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (k % 2 == 0) begin
            jmax = 64'((lvl[b] < TMAX - lvl[b]) ? lvl[b] : TMAX - lvl[b]);
            if (jmax > 255) jmax = 255;
            jit[b] = tick_t'($urandom_range(0, int'(jmax)));
            r.tick[b] = lvl[b] + jit[b];
          end else begin
            r.tick[b] = lvl[b] - jit[b];
          end
        end
        r.cal = (k == ROUNDS - 1) ? cal : 1'($urandom_range(0, 1));
      end
      send_round(r, done, res);
      if (done) scan_results_due.push_back(res);
    end
  endtask

  // Presents one register write; the caller lowers valid after the series.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_THRESHOLD:  thr_reg = data[THR_W-1:0];
      CFG_SLIDE_DLT:  slide_reg = data[SLIDE_W-1:0];
      CFG_SLIDE_ONLY: drop_points_reg = data[0];
      default: ;
    endcase
  endtask

  // Stops offering rounds and lets the block go quiet.
  task automatic drain_block();
    push <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Compares one transferred result with the oldest expectation.
  task automatic take_result();
    result_t want;
    if (scan_results_due.size() == 0) begin
      report_mismatch("result with nothing expected, touched_button",
                      32'(touched_button_o), 0);
    end else begin
      want = scan_results_due.pop_front();
      scans_checked++;
      if (touched_button_o !== want.touched)
        report_mismatch("touched_button", 32'(touched_button_o), 32'(want.touched));
      if (gesture_valid_o !== want.gvalid)
        report_mismatch("gesture_valid", 32'(gesture_valid_o), 32'(want.gvalid));
      if (gesture_kind_o !== want.kind)
        report_mismatch("gesture_kind", 32'(gesture_kind_o), 32'(want.kind));
      if (down_button_o !== want.down)
        report_mismatch("down_button", 32'(down_button_o), 32'(want.down));
      if (up_button_o !== want.up)
        report_mismatch("up_button", 32'(up_button_o), 32'(want.up));
      if (want.gvalid) begin
        case (want.kind)
          KIND_POINT: points_seen++;
          KIND_RIGHT: rights_seen++;
          default:    lefts_seen++;
        endcase
      end
    end
  endtask

  // Result side: random pop idling, plus a long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) take_result();
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Main sequence: reset, directed table, then the random phases.
  initial begin
    round_t  r;
    result_t res;
    bit      done;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      sum_acc[b] = '0;
      base_avg[b] = '0;
    end
    rounds_in_scan = 0;
    gesture_live = 1'b0;
    press_btn = '0;
    lift_btn = '0;
    thr_reg = THRESHOLD_RST;
    slide_reg = SLIDE_DLT_RST;
    drop_points_reg = 1'b0;
    touch_run = 0;
    hold_request = 1'b0;
    mismatches = 0;
    rounds_sent = 0;
    scans_checked = 0;
    input_stalls = 0;
    points_seen = 0;
    rights_seen = 0;
    lefts_seen = 0;
    send_idle_pct = phases[0].send_pct;
    recv_idle_pct = phases[0].recv_pct;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; typed rows stand in for the prediction.
    for (int i = 0; i < $size(directed_rows); i++) begin
      r.tick[0] = directed_rows[i].t0;
      r.tick[1] = directed_rows[i].t1;
      r.tick[2] = directed_rows[i].t2;
      r.tick[3] = directed_rows[i].t3;
      r.cal = directed_rows[i].cal;
      send_round(r, done, res);
      if (done) scan_results_due.push_back(directed_rows[i].typed ? directed_rows[i].want : res);
    end
    drain_block();

    // Random phases, each under its own register setting.
    foreach (phases[p]) begin
      write_reg(CFG_THRESHOLD, CFG_DATA_W'(phases[p].thr));
      write_reg(CFG_SLIDE_DLT, {(CFG_DATA_W-SLIDE_W)'($urandom),
                                SLIDE_W'(phases[p].slide)});
      write_reg(CFG_SLIDE_ONLY, {(CFG_DATA_W-1)'($urandom), phases[p].only});
      cfg_valid_i <= 1'b0;
      send_idle_pct = phases[p].send_pct;
      recv_idle_pct = phases[p].recv_pct;
      if (phases[p].squeeze) hold_request = 1'b1;
      repeat (phases[p].scans) send_scan();
      drain_block();
    end

    $display("Covered %0d rounds and %0d checked scans over %0d register settings.",
             rounds_sent, scans_checked, $size(phases) + 1);
    $display("Gestures: %0d point, %0d slide right, %0d slide left; input stalled %0d cycles.",
             points_seen, rights_seen, lefts_seen, input_stalls);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("timeout with %0d scan results outstanding", scan_results_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[cap_touch_scan_gesture_top.f]
src/cts_pkg.sv
src/cts_cfg.sv
src/cts_front.sv
src/cts_back.sv
src/cap_touch_scan_gesture_top.sv
src/cts_checker.sv
tb/cap_touch_scan_gesture_tb.sv
